>>> rtl/lre_pkg.sv
package lre_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int RATIO_W     = 32;
   localparam int SUM_W       = 64;
   localparam int LEVEL_W     = 3;
   localparam int DIM_W       = 9;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 9;
   localparam int FRAC_W      = 16;

   localparam int DEFAULT_MAX_DIM   = 256;
   localparam int DEFAULT_MAX_LEVEL = 7;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_X = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_Y = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_Z = 8'd3;

   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 3'd1;
   localparam logic [DIM_W-1:0]   DIM_RESET   = 9'd256;

   localparam logic [RATIO_W-1:0] RATIO_ZERO = 32'h0000_0000;
   localparam logic [RATIO_W-1:0] RATIO_ONE  = 32'h0001_0000;
   localparam logic [RATIO_W-1:0] RATIO_SAT  = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_DECIDE,
      ST_DIVIDE,
      ST_STORE
   } lre_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_CHECK,
      DIV_RUN
   } lre_div_state_type;

   typedef struct packed {
      logic               start;
      logic [SUM_W-1:0]   num;
      logic [SUM_W-1:0]   den;
   } lre_div_req_type;

   typedef struct packed {
      logic               done;
      logic [RATIO_W-1:0] quot;
   } lre_div_rsp_type;

endpackage

>>> rtl/lre_div.sv
// Restoring divider: floor(num * 2^16 / den), saturated to 32 bits.
// One 66-bit subtractor shared by the range check and the 32 quotient steps.
module lre_div (
   input  logic                     clock,
   input  logic                     reset,
   input  lre_pkg::lre_div_req_type div_req,
   output lre_pkg::lre_div_rsp_type div_rsp
);

   localparam int SumW  = lre_pkg::SUM_W;
   localparam int QW    = lre_pkg::RATIO_W;
   localparam int FracW = lre_pkg::FRAC_W;
   localparam int CntW  = $clog2(QW);

   lre_pkg::lre_div_state_type state_ff, state_in;
   logic [SumW-1:0]  rem_ff, rem_in;
   logic [SumW-1:0]  den_ff, den_in;
   logic [FracW-1:0] low_ff, low_in;
   logic [QW-1:0]    quot_ff, quot_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             done_ff, done_in;

   logic [SumW:0]    shifted;
   logic [SumW:0]    sub_a;
   logic [SumW+1:0]  sub_res;
   logic             borrow;

   // next dividend bit: low 16 bits of num, then zeros
   assign shifted = {rem_ff, low_ff[FracW-1]};
   assign sub_a   = (state_ff == lre_pkg::DIV_CHECK) ? {1'b0, rem_ff} : shifted;
   assign sub_res = {1'b0, sub_a} - {2'b00, den_ff};
   assign borrow  = sub_res[SumW+1];

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      low_in   = low_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         lre_pkg::DIV_IDLE: begin
            if (div_req.start) begin
               rem_in   = {{FracW{1'b0}}, div_req.num[SumW-1:FracW]};
               low_in   = div_req.num[FracW-1:0];
               den_in   = div_req.den;
               cnt_in   = '0;
               state_in = lre_pkg::DIV_CHECK;
            end
         end
         lre_pkg::DIV_CHECK: begin
            // num >> 16 >= den means the quotient needs more than 16 integer bits
            if (!borrow) begin
               quot_in  = lre_pkg::RATIO_SAT;
               done_in  = 1'b1;
               state_in = lre_pkg::DIV_IDLE;
            end else begin
               state_in = lre_pkg::DIV_RUN;
            end
         end
         lre_pkg::DIV_RUN: begin
            rem_in  = borrow ? shifted[SumW-1:0] : sub_res[SumW-1:0];
            quot_in = {quot_ff[QW-2:0], ~borrow};
            low_in  = {low_ff[FracW-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(QW - 1)) begin
               done_in  = 1'b1;
               state_in = lre_pkg::DIV_IDLE;
            end
         end
         default: state_in = lre_pkg::DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lre_pkg::DIV_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

>>> rtl/lod_residual_error_core.sv
// Level-of-detail residual error estimator. Voxels of a brick stream in on the
// req_ channel in block order, one beat per cycle outside the stall after a
// last beat; each cube of 2^(3*level) voxels opens with its corner voxel.
// Every voxel adds |sample - corner| to an exact 64-bit error sum and sample
// to a 64-bit base sum (both saturating). The beat with req_tlast set closes
// the brick and yields one rsp_ beat: 0 for level 0; else 1.0 with rsp_tuser
// set when any dim >> level is below 4; else 0 for a zero base; else error/base
// as unsigned 16.16 (truncated, saturated to 0xFFFFFFFF). After a last beat
// the input stalls through a decide state, then the shared restoring divider
// (one range check plus 32 quotient steps on one 66-bit subtractor, plus a
// wait that sees its registered done), then the result write. A quotient that
// saturates ends the divider after the range check; the special cases skip the
// divider and write their result from the decide state. The stall stretches
// while the previous result still waits in the output register. The result
// sits in an output register, so the next brick may start streaming while it
// waits to be taken. Config writes land at once on the csr_ port (always ready)
// and should be made while the block is idle.
module lod_residual_error_core #(
   parameter int MAX_DIM   = lre_pkg::DEFAULT_MAX_DIM,
   parameter int MAX_LEVEL = lre_pkg::DEFAULT_MAX_LEVEL
) (
   input  logic                              clock,
   input  logic                              reset,
   // voxel beats
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lre_pkg::SAMPLE_W-1:0]      req_tdata,   // [31:0] sample
   input  logic                              req_tlast,   // last voxel of brick
   // result beats
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lre_pkg::RATIO_W-1:0]       rsp_tdata,   // [31:0] error_ratio
   output logic                              rsp_tuser,   // [0] too_coarse
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lre_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lre_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int SumW    = lre_pkg::SUM_W;
   localparam int SampleW = lre_pkg::SAMPLE_W;
   localparam int LevelW  = lre_pkg::LEVEL_W;
   localparam int DimW    = lre_pkg::DIM_W;
   localparam int RatioW  = lre_pkg::RATIO_W;
   // cube position: 3 bits per level
   localparam int PosW    = 3 * MAX_LEVEL;
   // compare width wide enough for both the register and MAX_DIM
   localparam int DimCmpW = ($clog2(MAX_DIM + 1) > DimW) ? $clog2(MAX_DIM + 1) : DimW;

   // ---------------- configuration registers ----------------
   logic [LevelW-1:0] level_ff, level_in;
   logic [DimW-1:0]   dim_x_ff, dim_x_in;
   logic [DimW-1:0]   dim_y_ff, dim_y_in;
   logic [DimW-1:0]   dim_z_ff, dim_z_in;
   logic              csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      level_in = level_ff;
      dim_x_in = dim_x_ff;
      dim_y_in = dim_y_ff;
      dim_z_in = dim_z_ff;
      if (csr_write) begin
         // writes past the last register index fall through and are dropped
         priority case (csr_index)
            lre_pkg::CSR_LEVEL: level_in = csr_data[LevelW-1:0];
            lre_pkg::CSR_DIM_X: dim_x_in = csr_data[DimW-1:0];
            lre_pkg::CSR_DIM_Y: dim_y_in = csr_data[DimW-1:0];
            lre_pkg::CSR_DIM_Z: dim_z_in = csr_data[DimW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= lre_pkg::LEVEL_RESET;
         dim_x_ff <= lre_pkg::DIM_RESET;
         dim_y_ff <= lre_pkg::DIM_RESET;
         dim_z_ff <= lre_pkg::DIM_RESET;
      end else begin
         level_ff <= level_in;
         dim_x_ff <= dim_x_in;
         dim_y_ff <= dim_y_in;
         dim_z_ff <= dim_z_in;
      end
   end

   // ---------------- derived level, cube mask, coarse check ----------------
   logic [LevelW-1:0] lv;
   logic [PosW-1:0]   pos_mask;
   logic              lv_zero;
   logic              coarse;

   assign lv      = (int'(level_ff) > MAX_LEVEL) ? LevelW'(MAX_LEVEL) : level_ff;
   assign lv_zero = (lv == '0);

   always_comb begin
      for (int i = 0; i < PosW; i++) begin
         pos_mask[i] = (i < 3 * int'(lv));
      end
   end

   // dimension clamped to MAX_DIM, then reduced by the level
   function automatic logic dim_small(input logic [DimW-1:0] d,
                                      input logic [LevelW-1:0] l);
      logic [DimCmpW-1:0] dw;
      logic [DimCmpW-1:0] dc;
      dw = DimCmpW'(d);
      dc = (dw > DimCmpW'(MAX_DIM)) ? DimCmpW'(MAX_DIM) : dw;
      return (dc >> l) < DimCmpW'(4);
   endfunction

   assign coarse = dim_small(dim_x_ff, lv) | dim_small(dim_y_ff, lv) |
                   dim_small(dim_z_ff, lv);

   // ---------------- accumulator ----------------
   logic [SampleW-1:0] corner_ff, corner_in;
   logic [SumW-1:0]    err_sum_ff, err_sum_in;
   logic [SumW-1:0]    base_sum_ff, base_sum_in;
   logic [PosW-1:0]    pos_ff, pos_in;

   logic               req_accept;
   logic               clear_acc;
   logic [PosW-1:0]    pos_cur;
   logic [SampleW-1:0] corner_cur;
   logic [SampleW-1:0] abs_diff;
   logic [SumW:0]      err_add;
   logic [SumW:0]      base_add;

   assign req_accept = req_tvalid & req_tready;

   // position wraps to the current cube size, also after a mid-brick level change
   assign pos_cur    = pos_ff & pos_mask;
   assign corner_cur = (pos_cur == '0) ? req_tdata : corner_ff;
   assign abs_diff   = (req_tdata >= corner_cur) ? (req_tdata - corner_cur)
                                                 : (corner_cur - req_tdata);
   assign err_add    = {1'b0, err_sum_ff} + {1'b0, SumW'(abs_diff)};
   assign base_add   = {1'b0, base_sum_ff} + {1'b0, SumW'(req_tdata)};

   always_comb begin
      corner_in   = corner_ff;
      err_sum_in  = err_sum_ff;
      base_sum_in = base_sum_ff;
      pos_in      = pos_ff;
      priority if (clear_acc) begin
         corner_in   = '0;
         err_sum_in  = '0;
         base_sum_in = '0;
         pos_in      = '0;
      end else if (req_accept) begin
         corner_in   = corner_cur;
         err_sum_in  = err_add[SumW] ? {SumW{1'b1}} : err_add[SumW-1:0];
         base_sum_in = base_add[SumW] ? {SumW{1'b1}} : base_add[SumW-1:0];
         pos_in      = (pos_cur + 1'b1) & pos_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff   <= '0;
         err_sum_ff  <= '0;
         base_sum_ff <= '0;
         pos_ff      <= '0;
      end else begin
         corner_ff   <= corner_in;
         err_sum_ff  <= err_sum_in;
         base_sum_ff <= base_sum_in;
         pos_ff      <= pos_in;
      end
   end

   // ---------------- shared divider ----------------
   lre_pkg::lre_div_req_type div_req;
   lre_pkg::lre_div_rsp_type div_rsp;
   logic                     div_start;

   assign div_req.start = div_start;
   assign div_req.num   = err_sum_ff;
   assign div_req.den   = base_sum_ff;

   lre_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------- sequencer ----------------
   lre_pkg::lre_state_type state_ff, state_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [RatioW-1:0] rsp_ratio_ff, rsp_ratio_in;
   logic              rsp_coarse_ff, rsp_coarse_in;
   logic              rsp_free;
   logic              load_rsp;
   logic [RatioW-1:0] load_ratio;
   logic              load_coarse;

   // output slot can take a new result when empty or being drained this cycle
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == lre_pkg::ST_ACCUM);

   always_comb begin
      state_in    = state_ff;
      load_rsp    = 1'b0;
      load_ratio  = lre_pkg::RATIO_ZERO;
      load_coarse = 1'b0;
      div_start   = 1'b0;
      clear_acc   = 1'b0;
      unique case (state_ff)
         lre_pkg::ST_ACCUM: begin
            if (req_accept && req_tlast) begin
               state_in = lre_pkg::ST_DECIDE;
            end
         end
         lre_pkg::ST_DECIDE: begin
            // sums now include the last voxel
            if (lv_zero || coarse || (base_sum_ff == '0)) begin
               load_coarse = ~lv_zero & coarse;
               load_ratio  = load_coarse ? lre_pkg::RATIO_ONE : lre_pkg::RATIO_ZERO;
               if (rsp_free) begin
                  load_rsp  = 1'b1;
                  clear_acc = 1'b1;
                  state_in  = lre_pkg::ST_ACCUM;
               end
            end else begin
               // divider latches the sums, so they can be cleared now
               div_start = 1'b1;
               clear_acc = 1'b1;
               state_in  = lre_pkg::ST_DIVIDE;
            end
         end
         lre_pkg::ST_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = lre_pkg::ST_STORE;
            end
         end
         lre_pkg::ST_STORE: begin
            load_ratio = div_rsp.quot;
            if (rsp_free) begin
               load_rsp = 1'b1;
               state_in = lre_pkg::ST_ACCUM;
            end
         end
         default: state_in = lre_pkg::ST_ACCUM;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_ratio_in  = rsp_ratio_ff;
      rsp_coarse_in = rsp_coarse_ff;
      priority if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_ratio_in  = load_ratio;
         rsp_coarse_in = load_coarse;
      end else if (rsp_tready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lre_pkg::ST_ACCUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ratio_ff  <= rsp_ratio_in;
      rsp_coarse_ff <= rsp_coarse_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ratio_ff;
   assign rsp_tuser  = rsp_coarse_ff;

endmodule

>>> rtl/lre_checker.sv
module lre_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          req_tlast,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [lre_pkg::RATIO_W-1:0]   rsp_tdata,
   input logic                          rsp_tuser
);

   // bricks closed on the input minus results taken on the output
   logic [1:0] pending_ff, pending_in;
   logic       last_beat;
   logic       rsp_beat;

   assign last_beat = req_tvalid & req_tready & req_tlast;
   assign rsp_beat  = rsp_tvalid & rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (last_beat && !rsp_beat) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_beat && !last_beat) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_coarse_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == lre_pkg::RATIO_ONE)
      else $error("coarse result must carry 1.0");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("result beat with no closed brick");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two bricks awaiting results");

   a_stall_after_last: assert property (@(posedge clock) disable iff (reset)
      last_beat |=> !req_tready)
      else $error("input taken right after a last beat");

endmodule

bind lod_residual_error_core lre_checker u_lre_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
